### hw/rtl/grid_ray_traversal_assert.svh
// ----------------------------------------------------------------------------
// Grid ray traversal assertion macros
// Concurrent assertion helpers, sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_TRAVERSAL_ASSERT_SVH
`define GRID_RAY_TRAVERSAL_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GRT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GRT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/grt_pkg.sv
// ----------------------------------------------------------------------------
// Grid ray traversal package
// Shared widths, command and status types for controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grt_pkg;

    localparam int FRAC_BITS = 8;
    localparam int IN_W      = 24;   // pixel position ports
    localparam int POS_W     = 25;   // position in cell units, Q.8
    localparam int CELL_W    = 17;   // signed cell coordinate
    localparam int DIR_W     = 10;   // signed direction, +-256
    localparam int DIV_W     = 34;   // divider numerator / quotient
    localparam int DEN_W     = 26;   // divider denominator
    localparam int ROOT_W    = 50;   // square root radicand
    localparam int ROOT_STEPS = 25;
    localparam int IDX_W     = 15;   // row * width + column

    localparam logic [1:0] CFG_MAP_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_CELL_SIZE    = 2'd2;
    localparam logic [1:0] CFG_MAX_DISTANCE = 2'd3;

    localparam logic [7:0] TILE_WALL = 8'd1;
    localparam logic       FUNC_WRITE = 1'b0;

    typedef enum logic [2:0] {
        DS_SX, DS_SY, DS_EX, DS_EY, DS_DIRX, DS_DIRY, DS_UNX, DS_UNY
    } div_sel_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_TILE_WR, OP_LOAD, OP_DIV_GO, OP_DIV_TAKE, OP_SQUARE,
        OP_SQRT_INIT, OP_SQRT_STEP, OP_CELL, OP_READ, OP_EDGE, OP_STEP,
        OP_FOUND, OP_FIN_MUL, OP_FIN_POS, OP_OUT_HIT, OP_OUT_BLOCKED
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_SQUARE, ST_SQRT_INIT, ST_SQRT,
        ST_CELL, ST_CELL_RD, ST_CELL_CHK, ST_EDGE, ST_TEST, ST_STEP,
        ST_READ, ST_CHECK, ST_FIN_MUL, ST_FIN_POS, ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t   op;
        div_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_last;
        logic blocked;
        logic wall;
        logic more;
    } dp_status_t;

    // saturate a 33-bit sum to 32 bits
    function automatic logic [31:0] sat32(input logic [32:0] v);
        sat32 = v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // saturate a signed 45-bit value to signed 24 bits
    function automatic logic [IN_W-1:0] sat_s24(input logic signed [44:0] v);
        logic signed [44:0] hi;
        logic signed [44:0] lo;
        hi = 45'sd8388607;
        lo = -45'sd8388608;
        if (v > hi)
            sat_s24 = 24'h7FFFFF;
        else if (v < lo)
            sat_s24 = 24'h800000;
        else
            sat_s24 = v[IN_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/grt_div.sv
// ----------------------------------------------------------------------------
// Grid ray traversal divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grt_div
    import grt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [DIV_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [DIV_W-1:0]      quo,
    output logic                  rem_nz
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   trial;

    // shift in the next numerator bit and try a subtract
    always_comb
    begin
        trial       = {rem_reg, quo_reg[DIV_W-1]};
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        if (go)
        begin
            quo_next    = num;
            rem_next    = '0;
            cnt_next    = CNT_W'(DIV_W);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = DEN_W'(trial - {1'b0, den});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // hold control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    // advance the working words
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign quo    = quo_reg;
    assign rem_nz = (rem_reg != '0);

endmodule

`default_nettype wire

### hw/rtl/grt_ctrl.sv
// ----------------------------------------------------------------------------
// Grid ray traversal controller
// Sequences set-up divisions, square root, start check and the cell walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grt_ctrl
    import grt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       func,
    input  dp_status_t      status,
    output dp_cmd_t         cmd,
    output logic            busy
);

    ctrl_state_t state_reg, state_next;
    div_sel_t    sel_reg, sel_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= DS_SX;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_IDLE;
        cmd.sel    = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_WRITE)
                        cmd.op = OP_TILE_WR;
                    else
                    begin
                        cmd.op     = OP_LOAD;
                        sel_next   = DS_SX;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO:
            begin
                cmd.op     = OP_DIV_GO;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = OP_DIV_TAKE;
                    case (sel_reg)
                        DS_EY:   state_next = ST_SQUARE;
                        DS_DIRY: state_next = ST_CELL;
                        DS_UNY:  state_next = ST_EDGE;
                        default:
                        begin
                            sel_next   = div_sel_t'(3'(sel_reg + 3'd1));
                            state_next = ST_DIV_GO;
                        end
                    endcase
                end
            end
            ST_SQUARE:
            begin
                cmd.op     = OP_SQUARE;
                state_next = ST_SQRT_INIT;
            end
            ST_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                if (status.sqrt_last)
                begin
                    sel_next   = DS_DIRX;
                    state_next = ST_DIV_GO;
                end
            end
            ST_CELL:
            begin
                cmd.op     = OP_CELL;
                state_next = ST_CELL_RD;
            end
            ST_CELL_RD:
            begin
                cmd.op     = OP_READ;
                state_next = ST_CELL_CHK;
            end
            ST_CELL_CHK:
            begin
                if (status.blocked)
                begin
                    cmd.op     = OP_OUT_BLOCKED;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sel_next   = DS_UNX;
                    state_next = ST_DIV_GO;
                end
            end
            ST_EDGE:
            begin
                cmd.op     = OP_EDGE;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = status.more ? ST_STEP : ST_FIN_MUL;
            end
            ST_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.op     = OP_READ;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.wall)
                begin
                    cmd.op     = OP_FOUND;
                    state_next = ST_FIN_MUL;
                end
                else
                    state_next = status.more ? ST_STEP : ST_FIN_MUL;
            end
            ST_FIN_MUL:
            begin
                cmd.op     = OP_FIN_MUL;
                state_next = ST_FIN_POS;
            end
            ST_FIN_POS:
            begin
                cmd.op     = OP_FIN_POS;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.op     = OP_OUT_HIT;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

### hw/rtl/grt_dp.sv
// ----------------------------------------------------------------------------
// Grid ray traversal datapath
// Tile memory, configuration, set-up arithmetic, walk registers and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grt_dp
    import grt_pkg::*;
#(
    parameter int MAP_CELLS = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire logic [11:0]            tile_index,
    input  wire logic [7:0]             tile_value,
    input  wire logic signed [IN_W-1:0] start_x,
    input  wire logic signed [IN_W-1:0] start_y,
    input  wire logic signed [IN_W-1:0] end_x,
    input  wire logic signed [IN_W-1:0] end_y,
    input  dp_cmd_t                     cmd,
    output dp_status_t                  status,
    output logic                        done,
    output logic                        hit,
    output logic signed [IN_W-1:0]      hit_x,
    output logic signed [IN_W-1:0]      hit_y,
    output logic [IN_W-1:0]             distance
);

    localparam int AW = $clog2(MAP_CELLS);

    // configuration
    logic [6:0] map_w_reg, map_h_reg;
    logic [7:0] cell_size_reg, max_dist_reg;
    logic [7:0] cs;

    // captured inputs and set-up values
    logic signed [IN_W-1:0]   in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg;
    logic signed [POS_W-1:0]  sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DIR_W-1:0]  dirx_reg, diry_reg;
    logic [31:0]              unx_reg, uny_reg;
    logic [ROOT_W-2:0]        sqx_reg, sqy_reg;
    logic [ROOT_W-1:0]        rv_reg, rr_reg, rbit_reg;
    logic [4:0]               rcnt_reg;

    // walk
    logic signed [CELL_W-1:0] col_reg, row_reg;
    logic [31:0]              edx_reg, edy_reg, trav_reg;
    logic                     found_reg;
    logic [7:0]               rd_data_reg;
    logic                     inb_reg;
    logic                     inmap_reg;

    // finish
    logic signed [42:0]       mulx_reg, muly_reg;
    logic [39:0]              dist_reg;
    logic signed [44:0]       px_reg, py_reg;

    // result
    logic                     done_reg;
    logic                     hit_reg;
    logic [IN_W-1:0]          hit_x_reg, hit_y_reg, dist_out_reg;

    logic [7:0]               tile_mem [MAP_CELLS];

    // divider
    logic [DIV_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic             div_done, div_rem_nz;

    assign cs = (cell_size_reg == 8'd0) ? 8'd1 : cell_size_reg;

    // direction differences and magnitudes
    logic signed [POS_W:0] dx, dy, dx_neg, dy_neg;
    logic [POS_W-1:0]      adx, ady;
    logic [DIR_W-1:0]      dirx_neg, diry_neg;
    logic [DIR_W-2:0]      adirx, adiry;
    logic [POS_W-1:0]      len;

    assign dx     = {ex_reg[POS_W-1], ex_reg} - {sx_reg[POS_W-1], sx_reg};
    assign dy     = {ey_reg[POS_W-1], ey_reg} - {sy_reg[POS_W-1], sy_reg};
    assign dx_neg = -dx;
    assign dy_neg = -dy;
    assign adx    = dx[POS_W] ? dx_neg[POS_W-1:0] : dx[POS_W-1:0];
    assign ady    = dy[POS_W] ? dy_neg[POS_W-1:0] : dy[POS_W-1:0];
    assign dirx_neg = -dirx_reg;
    assign diry_neg = -diry_reg;
    assign adirx  = dirx_reg[DIR_W-1] ? dirx_neg[DIR_W-2:0] : dirx_reg[DIR_W-2:0];
    assign adiry  = diry_reg[DIR_W-1] ? diry_neg[DIR_W-2:0] : diry_reg[DIR_W-2:0];
    assign len    = rr_reg[POS_W-1:0];

    // magnitude of a captured input position
    logic signed [IN_W-1:0] fsrc;
    logic [IN_W-1:0]        fsrc_neg, fsrc_mag;

    always_comb
    begin
        case (cmd.sel)
            DS_SX:   fsrc = in_sx_reg;
            DS_SY:   fsrc = in_sy_reg;
            DS_EX:   fsrc = in_ex_reg;
            default: fsrc = in_ey_reg;
        endcase
    end

    assign fsrc_neg = -fsrc;
    assign fsrc_mag = fsrc[IN_W-1] ? fsrc_neg : fsrc;

    // divider operand select
    always_comb
    begin
        case (cmd.sel)
            DS_DIRX:
            begin
                div_num = DIV_W'({adx, 8'd0});
                div_den = DEN_W'(len);
            end
            DS_DIRY:
            begin
                div_num = DIV_W'({ady, 8'd0});
                div_den = DEN_W'(len);
            end
            DS_UNX:
            begin
                div_num = DIV_W'(1) << (2 * FRAC_BITS);
                div_den = DEN_W'(adirx);
            end
            DS_UNY:
            begin
                div_num = DIV_W'(1) << (2 * FRAC_BITS);
                div_den = DEN_W'(adiry);
            end
            default:
            begin
                div_num = DIV_W'(fsrc_mag);
                div_den = DEN_W'(cs);
            end
        endcase
    end

    grt_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cmd.op == OP_DIV_GO),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo),
        .rem_nz (div_rem_nz)
    );

    // floor division result, normalized direction, unit step
    logic [POS_W-1:0]        fq;
    logic signed [POS_W-1:0] floor_q;
    logic [DIR_W-1:0]        dq;
    logic signed [DIR_W-1:0] dir_q;
    logic                    dir_src_neg;
    logic [DIR_W-2:0]        unit_src;
    logic [31:0]             unit_q;

    assign fq      = div_quo[POS_W-1:0];
    assign floor_q = fsrc[IN_W-1] ? (POS_W'(0) - fq - POS_W'(div_rem_nz)) : fq;
    assign dq      = div_quo[DIR_W-1:0];
    assign dir_src_neg = (cmd.sel == DS_DIRX) ? dx[POS_W] : dy[POS_W];
    assign dir_q   = (len == '0) ? '0 : (dir_src_neg ? -dq : dq);
    assign unit_src = (cmd.sel == DS_UNX) ? adirx : adiry;
    assign unit_q  = (unit_src == '0) ? 32'hFFFF_FFFF : div_quo[31:0];

    // integer square root step
    logic [ROOT_W-1:0] rtrial;
    assign rtrial = rr_reg + rbit_reg;

    // first edge lengths
    logic [FRAC_BITS:0] partx, party;
    logic [40:0]        eprodx, eprody;

    assign partx  = dirx_reg[DIR_W-1] ? {1'b0, sx_reg[7:0]} : (9'd256 - {1'b0, sx_reg[7:0]});
    assign party  = diry_reg[DIR_W-1] ? {1'b0, sy_reg[7:0]} : (9'd256 - {1'b0, sy_reg[7:0]});
    assign eprodx = 41'(partx) * 41'(unx_reg);
    assign eprody = 41'(party) * 41'(uny_reg);

    // map bounds and tile address of the current cell
    logic            col_ok, row_ok, idx_ok, inb;
    logic [IDX_W-1:0] idx;
    logic [31:0]     idx32;
    logic [AW-1:0]   rd_addr;

    assign col_ok  = !col_reg[CELL_W-1] && (col_reg[CELL_W-2:0] < 16'(map_w_reg));
    assign row_ok  = !row_reg[CELL_W-1] && (row_reg[CELL_W-2:0] < 16'(map_h_reg));
    assign idx     = IDX_W'(row_reg[6:0]) * IDX_W'(map_w_reg) + IDX_W'(col_reg[6:0]);
    assign idx32   = 32'(idx);
    assign idx_ok  = idx32 < 32'(MAP_CELLS);
    assign inb     = col_ok && row_ok && idx_ok;
    assign rd_addr = idx32[AW-1:0];

    // tile write address
    logic [31:0]   wr_idx32;
    logic [AW-1:0] wr_addr;
    logic          wr_ok;

    assign wr_idx32 = 32'(tile_index);
    assign wr_addr  = wr_idx32[AW-1:0];
    assign wr_ok    = wr_idx32 < 32'(MAP_CELLS);

    // walk step
    logic        step_x;
    logic [32:0] edx_sum, edy_sum;

    assign step_x  = edx_reg < edy_reg;
    assign edx_sum = {1'b0, edx_reg} + {1'b0, unx_reg};
    assign edy_sum = {1'b0, edy_reg} + {1'b0, uny_reg};

    // finish arithmetic
    logic signed [42:0] mulx, muly;
    logic signed [34:0] shx, shy;
    logic signed [35:0] sumx, sumy;
    logic signed [44:0] pmx, pmy;

    assign mulx = dirx_reg * $signed({1'b0, trav_reg});
    assign muly = diry_reg * $signed({1'b0, trav_reg});
    assign shx  = mulx_reg[42:FRAC_BITS];
    assign shy  = muly_reg[42:FRAC_BITS];
    assign sumx = {shx[34], shx} + {{11{sx_reg[POS_W-1]}}, sx_reg};
    assign sumy = {shy[34], shy} + {{11{sy_reg[POS_W-1]}}, sy_reg};
    assign pmx  = sumx * $signed({1'b0, cs});
    assign pmy  = sumy * $signed({1'b0, cs});

    // tile memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_TILE_WR && wr_ok)
            tile_mem[wr_addr] <= tile_value;
        if (cmd.op == OP_READ)
            rd_data_reg <= tile_mem[rd_addr];
    end

    // configuration and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg     <= 7'd64;
            map_h_reg     <= 7'd64;
            cell_size_reg <= 8'd64;
            max_dist_reg  <= 8'd100;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:    map_w_reg     <= cfg_data[6:0];
                    CFG_MAP_HEIGHT:   map_h_reg     <= cfg_data[6:0];
                    CFG_CELL_SIZE:    cell_size_reg <= cfg_data;
                    CFG_MAX_DISTANCE: max_dist_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            done_reg <= (cmd.op == OP_OUT_HIT) || (cmd.op == OP_OUT_BLOCKED);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                in_sx_reg <= start_x;
                in_sy_reg <= start_y;
                in_ex_reg <= end_x;
                in_ey_reg <= end_y;
            end
            OP_DIV_TAKE:
            begin
                case (cmd.sel)
                    DS_SX:   sx_reg   <= floor_q;
                    DS_SY:   sy_reg   <= floor_q;
                    DS_EX:   ex_reg   <= floor_q;
                    DS_EY:   ey_reg   <= floor_q;
                    DS_DIRX: dirx_reg <= dir_q;
                    DS_DIRY: diry_reg <= dir_q;
                    DS_UNX:  unx_reg  <= unit_q;
                    default: uny_reg  <= unit_q;
                endcase
            end
            OP_SQUARE:
            begin
                sqx_reg <= (ROOT_W-1)'(adx) * (ROOT_W-1)'(adx);
                sqy_reg <= (ROOT_W-1)'(ady) * (ROOT_W-1)'(ady);
            end
            OP_SQRT_INIT:
            begin
                rv_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
                rr_reg   <= '0;
                rbit_reg <= ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
                rcnt_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                if (rv_reg >= rtrial)
                begin
                    rv_reg <= rv_reg - rtrial;
                    rr_reg <= (rr_reg >> 1) + rbit_reg;
                end
                else
                    rr_reg <= rr_reg >> 1;
                rbit_reg <= rbit_reg >> 2;
                rcnt_reg <= rcnt_reg + 5'd1;
            end
            OP_CELL:
            begin
                col_reg <= sx_reg[POS_W-1:FRAC_BITS];
                row_reg <= sy_reg[POS_W-1:FRAC_BITS];
            end
            OP_READ:
            begin
                inb_reg   <= inb;
                inmap_reg <= col_ok && row_ok;
            end
            OP_EDGE:
            begin
                edx_reg   <= sat32(eprodx[40:FRAC_BITS]);
                edy_reg   <= sat32(eprody[40:FRAC_BITS]);
                trav_reg  <= '0;
                found_reg <= 1'b0;
            end
            OP_STEP:
            begin
                if (step_x)
                begin
                    col_reg  <= dirx_reg[DIR_W-1] ? col_reg - 1'b1 : col_reg + 1'b1;
                    trav_reg <= edx_reg;
                    edx_reg  <= sat32(edx_sum);
                end
                else
                begin
                    row_reg  <= diry_reg[DIR_W-1] ? row_reg - 1'b1 : row_reg + 1'b1;
                    trav_reg <= edy_reg;
                    edy_reg  <= sat32(edy_sum);
                end
            end
            OP_FOUND:
            begin
                found_reg <= 1'b1;
            end
            OP_FIN_MUL:
            begin
                mulx_reg <= mulx;
                muly_reg <= muly;
                dist_reg <= 40'(trav_reg) * 40'(cs);
            end
            OP_FIN_POS:
            begin
                px_reg <= pmx;
                py_reg <= pmy;
            end
            OP_OUT_HIT:
            begin
                hit_reg      <= found_reg;
                hit_x_reg    <= found_reg ? sat_s24(px_reg) : '0;
                hit_y_reg    <= found_reg ? sat_s24(py_reg) : '0;
                dist_out_reg <= (dist_reg[39:IN_W] != '0) ? 24'hFFFFFF : dist_reg[IN_W-1:0];
            end
            OP_OUT_BLOCKED:
            begin
                hit_reg      <= 1'b0;
                hit_x_reg    <= in_sx_reg;
                hit_y_reg    <= in_sy_reg;
                dist_out_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    // status to the controller; a start cell in the map but past the store
    // reads as open floor, so only the map bounds and a wall block the start
    assign status.div_done  = div_done;
    assign status.sqrt_last = (rcnt_reg == 5'(ROOT_STEPS - 1));
    assign status.blocked   = !inmap_reg || (inb_reg && (rd_data_reg == TILE_WALL));
    assign status.wall      = inb_reg && (rd_data_reg == TILE_WALL);
    assign status.more      = trav_reg < 32'({max_dist_reg, 8'd0});

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign hit_x    = hit_x_reg;
    assign hit_y    = hit_y_reg;
    assign distance = dist_out_reg;

endmodule

`default_nettype wire

### hw/rtl/grid_ray_traversal.sv
// ----------------------------------------------------------------------------
// Grid ray traversal
// Tile map store and DDA ray walk over cells, Q.8 fixed point.
//
//   channel   handshake           word
//   --------  ------------------  ------------------------------------------
//   config    cfg_wr_en           cfg_index, cfg_data
//   command   start / busy        func, tile_index, tile_value, start/end xy
//   result    done (one cycle)    hit, hit_x, hit_y, distance
//
// A tile write is taken while idle, does not raise busy and gives no result word.
// A cast runs its set-up (eight passes of the shared divider plus a
// 25-step square root), then takes each cell stepped through the step,
// read and check states, the read being the registered tile memory read.
// Reset is asynchronous and active low; no clearing pass is run.
// The result word shows for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_ray_traversal_assert.svh"

module grid_ray_traversal
    import grt_pkg::*;
#(
    parameter int MAP_CELLS = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   func,
    input  wire logic [11:0]            tile_index,
    input  wire logic [7:0]             tile_value,
    input  wire logic signed [IN_W-1:0] start_x,
    input  wire logic signed [IN_W-1:0] start_y,
    input  wire logic signed [IN_W-1:0] end_x,
    input  wire logic signed [IN_W-1:0] end_y,
    output logic                        done,
    output logic                        hit,
    output logic signed [IN_W-1:0]      hit_x,
    output logic signed [IN_W-1:0]      hit_y,
    output logic [IN_W-1:0]             distance
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    grt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // arithmetic and tile store
    grt_dp #(
        .MAP_CELLS (MAP_CELLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tile_index (tile_index),
        .tile_value (tile_value),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .cmd        (cmd),
        .status     (status),
        .done       (done),
        .hit        (hit),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .distance   (distance)
    );

    // a cast always occupies the block, a result only lands once it is idle
    `GRT_ASSERT_NEXT(a_cast_busy, start && !busy && func, busy, "cast did not raise busy")
    `GRT_ASSERT_IMPLY(a_done_idle, done, !busy, "result word while busy")
    `GRT_ASSERT_NEXT(a_done_pulse, done, !done, "result word held over two cycles")

endmodule

`default_nettype wire
